/* design/ms_pkg.sv */
// ----------------------------------------------------------------------------
// ms_pkg
// Shared types and constants for the merge sorter: sequencer states and
// the result record passed from the sort core to the output stage.
// ----------------------------------------------------------------------------
package ms_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PRIME,
		ST_MERGE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} ms_state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     final_res;
		logic                     overflow;
	} ms_emit_t;

endpackage

/* design/ms_ram.sv */
// ----------------------------------------------------------------------------
// ms_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                       rdata_a,
	output logic [WIDTH-1:0]                       rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* design/ms_sort_core.sv */
// ----------------------------------------------------------------------------
// ms_sort_core
// Load, merge-pass and read-out sequencer around two ping-pong buffers.
// Each merge cycle reads both run heads, writes the smaller to the other
// buffer and steps the run pointers.
// ----------------------------------------------------------------------------
module ms_sort_core #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [ms_pkg::DATA_W-1:0] in_value,
	input  logic                             in_last,
	input  logic                             out_free,
	output logic                             emit_valid,
	output ms_pkg::ms_emit_t                 emit_item
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = AW + 1;
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);

	ms_pkg::ms_state_t state_q, state_d;
	logic              parity_q, parity_d;
	logic              dropped_q, dropped_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW-1:0]     a_q, a_d, b_q, b_d, mid_q, mid_d, hi_q, hi_d;
	logic [CW-1:0]     k_q, k_d, w_q, w_d;

	logic                             we0, we1;
	logic [AW-1:0]                    waddr0, waddr1, raddr_a, raddr_b;
	logic [ms_pkg::DATA_W-1:0]        wdata0, wdata1;
	logic [ms_pkg::DATA_W-1:0]        rd0_a, rd0_b, rd1_a, rd1_b;
	logic signed [ms_pkg::DATA_W-1:0] ra, rb, merge_val;
	logic                             take_a, pass_end;
	logic [CW-1:0]                    cnt_new, w2, base, step;
	logic [SW-1:0]                    mid_sum, hi_sum;
	logic [CW-1:0]                    mid_clip, hi_clip;

	ms_ram #(.WIDTH(ms_pkg::DATA_W), .DEPTH(MAX_ITEMS)) u_ram0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr0),
		.wdata  (wdata0),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd0_a),
		.rdata_b(rd0_b)
	);

	ms_ram #(.WIDTH(ms_pkg::DATA_W), .DEPTH(MAX_ITEMS)) u_ram1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr1),
		.wdata  (wdata1),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd1_a),
		.rdata_b(rd1_b)
	);

	assign ra        = parity_q ? rd1_a : rd0_a;
	assign rb        = parity_q ? rd1_b : rd0_b;
	assign take_a    = (a_q < mid_q) && ((b_q >= hi_q) || (ra <= rb));
	assign merge_val = take_a ? ra : rb;
	assign pass_end  = (hi_q == cnt_q);
	assign w2        = {w_q[CW-2:0], 1'b0};
	assign base      = pass_end ? '0 : hi_q;
	assign step      = pass_end ? w2 : w_q;
	assign mid_sum   = SW'(base) + SW'(step);
	assign hi_sum    = SW'(base) + (SW'(step) << 1);
	assign mid_clip  = (mid_sum > SW'(cnt_q)) ? cnt_q : mid_sum[CW-1:0];
	assign hi_clip   = (hi_sum > SW'(cnt_q)) ? cnt_q : hi_sum[CW-1:0];
	assign cnt_new   = (cnt_q < MAXC) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ms_pkg::ST_LOAD;
			parity_q  <= 1'b0;
			dropped_q <= 1'b0;
			cnt_q     <= '0;
			k_q       <= '0;
		end else begin
			state_q   <= state_d;
			parity_q  <= parity_d;
			dropped_q <= dropped_d;
			cnt_q     <= cnt_d;
			k_q       <= k_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q   <= a_d;
		b_q   <= b_d;
		mid_q <= mid_d;
		hi_q  <= hi_d;
		w_q   <= w_d;
	end

	always_comb begin
		state_d    = state_q;
		parity_d   = parity_q;
		dropped_d  = dropped_q;
		cnt_d      = cnt_q;
		a_d        = a_q;
		b_d        = b_q;
		mid_d      = mid_q;
		hi_d       = hi_q;
		k_d        = k_q;
		w_d        = w_q;
		in_ready   = 1'b0;
		emit_valid = 1'b0;
		emit_item  = '{value: ra, final_res: (k_q + 1'b1 == cnt_q), overflow: dropped_q};
		we0        = 1'b0;
		we1        = 1'b0;
		waddr0     = k_q[AW-1:0];
		waddr1     = k_q[AW-1:0];
		wdata0     = merge_val;
		wdata1     = merge_val;
		case (state_q)
			ms_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cnt_q < MAXC) begin
						we0    = 1'b1;
						waddr0 = cnt_q[AW-1:0];
						wdata0 = in_value;
					end else begin
						dropped_d = 1'b1;
					end
					cnt_d = cnt_new;
					if (in_last) begin
						parity_d = 1'b0;
						k_d      = '0;
						if (cnt_new >= CW'(2)) begin
							w_d     = CW'(1);
							a_d     = '0;
							b_d     = CW'(1);
							mid_d   = CW'(1);
							hi_d    = CW'(2);
							state_d = ms_pkg::ST_PRIME;
						end else begin
							state_d = ms_pkg::ST_EMIT_RD;
						end
					end
				end
			end
			ms_pkg::ST_PRIME: begin
				state_d = ms_pkg::ST_MERGE;
			end
			ms_pkg::ST_MERGE: begin
				we0 = parity_q;
				we1 = !parity_q;
				k_d = k_q + 1'b1;
				if (take_a) begin
					a_d = a_q + 1'b1;
				end else begin
					b_d = b_q + 1'b1;
				end
				if (k_q + 1'b1 == hi_q) begin
					a_d   = base;
					mid_d = mid_clip;
					b_d   = mid_clip;
					hi_d  = hi_clip;
					if (pass_end) begin
						parity_d = !parity_q;
						k_d      = '0;
						w_d      = w2;
						if (w2 < cnt_q) begin
							state_d = ms_pkg::ST_PRIME;
						end else begin
							state_d = ms_pkg::ST_EMIT_RD;
						end
					end
				end
			end
			ms_pkg::ST_EMIT_RD: begin
				if (out_free) begin
					state_d = ms_pkg::ST_EMIT_LD;
				end
			end
			ms_pkg::ST_EMIT_LD: begin
				emit_valid = 1'b1;
				k_d        = k_q + 1'b1;
				if (k_q + 1'b1 == cnt_q) begin
					cnt_d     = '0;
					dropped_d = 1'b0;
					k_d       = '0;
					state_d   = ms_pkg::ST_LOAD;
				end else begin
					state_d = ms_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ms_pkg::ST_LOAD;
			end
		endcase
	end

	assign raddr_a = (state_q == ms_pkg::ST_EMIT_RD) ? k_q[AW-1:0] : a_d[AW-1:0];
	assign raddr_b = b_d[AW-1:0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAXC)
		else $error("element count beyond capacity");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ms_pkg::ST_MERGE) |->
		(a_q <= mid_q) && (mid_q <= b_q) && (b_q <= hi_q) && (k_q < hi_q))
		else $error("merge run pointers out of order");

	a_emit_gap: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid |-> $past(state_q == ms_pkg::ST_EMIT_RD && out_free))
		else $error("result emitted without a granted read");

	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ms_pkg::ST_EMIT_RD || state_q == ms_pkg::ST_EMIT_LD) |->
		(k_q < cnt_q))
		else $error("read-out index beyond batch");

endmodule

/* design/merge_sorter.sv */
// ----------------------------------------------------------------------------
// merge_sorter
// Stable ascending sort of a batch of signed 32-bit values.
//
// Input stream: one value per transaction, s_tlast closes the batch. Up to
// MAX_ITEMS values are stored; later ones in the batch are dropped and
// m_tuser (overflow) is then high on every result of that batch.
// Output stream: the sorted batch, m_tlast on its final transaction.
// While loading, s_tready is high. Sorting runs ceil(log2 n) bottom-up
// merge passes over two ping-pong RAMs, each a priming state followed by
// one merged value per cycle through the dual read ports. Read-out then
// alternates a read state, which waits for a free output register, and
// a load state that moves the registered RAM read into that register.
// s_tready is low from the closing transaction until the last result has
// entered the output register. A stalled receiver holds the output
// register and read-out waits for it. Reset empties the batch and the
// output register; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module merge_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] sorted_value
	output logic        m_tlast,
	output logic        m_tuser   // [0] overflow
);

	logic             out_free;
	logic             emit_valid;
	ms_pkg::ms_emit_t emit_item;
	logic             m_valid_q;
	ms_pkg::ms_emit_t m_item_q;

	ms_sort_core #(.MAX_ITEMS(MAX_ITEMS)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata),
		.in_last   (s_tlast),
		.out_free  (out_free),
		.emit_valid(emit_valid),
		.emit_item (emit_item)
	);

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			m_item_q <= emit_item;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_item_q.value;
	assign m_tlast  = m_item_q.final_res;
	assign m_tuser  = m_item_q.overflow;

endmodule
